/* rtl/core/egd_pkg.sv */
// egd_pkg: shared types and constants for the exp-golomb decoder
// no dependencies; imported by every module in rtl/core
package egd_pkg;

	// a zero run of this many bits still starts a valid code
	localparam int unsigned MAX_ZEROS = 31;
	// counter width for zeros and suffix bits
	localparam int unsigned CNT_W = $clog2(MAX_ZEROS + 1);
	// width of the marker-plus-suffix word
	localparam int unsigned W_W = MAX_ZEROS + 1;
	localparam int unsigned VAL_W = 33;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] first_bit;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] code_value;
		logic                    code_error;
		logic                    last_of_byte;
	} out_word_t;

	// one finished code from the bit unit, value kept as the raw 1-prefixed word
	typedef struct packed {
		logic           valid;
		logic           err;
		logic [W_W-1:0] w;
	} code_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

endpackage

/* rtl/core/egd_bit_unit.sv */
// egd_bit_unit: code state registers and the one-bit decode step
// depends on egd_pkg
module egd_bit_unit
	import egd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      bit_in,
	output code_res_t res
);

	logic [CNT_W-1:0] zc_q;
	logic             in_suf_q;
	logic [W_W-1:0]   acc_q;
	logic [CNT_W-1:0] left_q;

	logic [CNT_W-1:0] zc_d;
	logic             in_suf_d;
	logic [W_W-1:0]   acc_d;
	logic [CNT_W-1:0] left_d;
	logic [W_W-1:0]   acc_sh;

	assign acc_sh = {acc_q[W_W-2:0], bit_in};

	always_comb begin
		zc_d     = zc_q;
		in_suf_d = in_suf_q;
		acc_d    = acc_q;
		left_d   = left_q;
		res      = '0;
		if (!in_suf_q) begin
			if (!bit_in) begin
				if (zc_q == CNT_W'(MAX_ZEROS)) begin
					// zero run too long: flag and start over
					res.valid = 1'b1;
					res.err   = 1'b1;
					zc_d      = '0;
				end else begin
					zc_d = zc_q + 1'b1;
				end
			end else if (zc_q == '0) begin
				res.valid = 1'b1;
				res.w     = W_W'(1);
			end else begin
				// marker bit seeds the word so it ends up as 2^n + suffix
				in_suf_d = 1'b1;
				left_d   = zc_q;
				acc_d    = W_W'(1);
			end
		end else begin
			acc_d  = acc_sh;
			left_d = left_q - 1'b1;
			if (left_q == CNT_W'(1)) begin
				res.valid = 1'b1;
				res.w     = acc_sh;
				zc_d      = '0;
				in_suf_d  = 1'b0;
				left_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q     <= '0;
			in_suf_q <= 1'b0;
			acc_q    <= '0;
			left_q   <= '0;
		end else if (step) begin
			zc_q     <= zc_d;
			in_suf_q <= in_suf_d;
			acc_q    <= acc_d;
			left_q   <= left_d;
		end
	end

endmodule

/* rtl/core/egd_value_map.sv */
// egd_value_map: turns the 1-prefixed code word into a ue or se value
// depends on egd_pkg
module egd_value_map
	import egd_pkg::*;
(
	input  logic                    signed_mode,
	input  logic                    err,
	input  logic [W_W-1:0]          w,
	output logic signed [VAL_W-1:0] value
);

	// w is ue + 1, so se is w/2 for even w and -(w/2) for odd w
	logic [VAL_W-1:0] half;
	logic [VAL_W-1:0] ue;

	assign half = VAL_W'(w[W_W-1:1]);
	assign ue   = VAL_W'(w) - VAL_W'(1);

	always_comb begin
		if (err) begin
			value = '0;
		end else if (!signed_mode) begin
			value = ue;
		end else if (w[0]) begin
			value = -half;
		end else begin
			value = half;
		end
	end

endmodule

/* rtl/core/exp_golomb_decoder.sv */
// exp_golomb_decoder: order-0 exp-golomb ue/se decoder, byte in, one code per word out
// depends on egd_pkg, egd_bit_unit, egd_value_map
//
// Takes one byte per input word and walks its bits from first_bit down to bit 0, one
// bit per cycle through a single shared bit unit unless a new code finds the held one
// blocked by a busy output; codes may span bytes. Every finished code gives one output
// word, the last one from a byte carrying last_of_byte. A run of 32 zeros gives a word
// with code_error set and value 0, and decoding restarts at the next bit. in_ready is
// high only while idle: a byte occupies the decoder for its bit walk plus a flush state
// that releases the held final code, longer when out_ready stalls. The user must write
// signed_mode with cfg_we only while the decoder is idle; not enforced by the block.
module exp_golomb_decoder
	import egd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	state_t state_q, state_d;

	logic            mode_q;
	logic [7:0]      byte_q;
	logic [2:0]      pos_q;
	logic            pend_v_q;
	code_res_t       pend_q;
	logic            out_v_q;
	out_word_t       out_q;

	code_res_t              res;
	logic                   step;
	logic                   out_busy;
	logic                   push_out;
	logic                   push_last;
	logic signed [VAL_W-1:0] pend_value;

	assign out_busy = out_v_q && !out_ready;

	egd_bit_unit u_bit (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.bit_in (byte_q[pos_q]),
		.res    (res)
	);

	egd_value_map u_map (
		.signed_mode (mode_q),
		.err         (pend_q.err),
		.w           (pend_q.w),
		.value       (pend_value)
	);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		step      = 1'b0;
		push_out  = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// a new code displaces the held one, which needs the output register free
				if (!(res.valid && pend_v_q && out_busy)) begin
					step     = 1'b1;
					push_out = res.valid && pend_v_q;
					if (pos_q == '0) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (!out_busy) begin
					push_out  = 1'b1;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_q <= in_data.data_byte;
			pos_q  <= in_data.first_bit;
		end else if (step && pos_q != '0) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	// held code: not known to be the last of its byte until the next one or the byte end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (step && res.valid) begin
			pend_v_q <= 1'b1;
		end else if (push_last) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			pend_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_out) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_q.code_value   <= pend_value;
			out_q.code_error   <= pend_q.err;
			out_q.last_of_byte <= push_last;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
